// File: rtl/swmmf_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median / mean filter: shared package
// Widths and sizes used by the filter, its channel interfaces and the core.
// ----------------------------------------------------------------------------
package swmmf_pkg;

  // Largest number of samples the window can hold.
  localparam int WIN_MAX  = 16;

  // Payload and register widths.
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // Index into the window storage and a count that can hold WIN_MAX itself.
  localparam int IDX_W    = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int LEN_W    = $clog2(WIN_MAX + 1);

  // Accumulator wide enough for WIN_MAX full-scale samples.
  localparam int SUM_W    = SAMPLE_W + LEN_W;
  localparam int DCNT_W   = $clog2(SUM_W + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = CFG_IDX_W'(1);

  // Reset values of the configuration registers.
  localparam int LEN_RESET = 5;

  // Filter modes.
  localparam logic MODE_MEDIAN = 1'b0;
  localparam logic MODE_MEAN   = 1'b1;

endpackage

// File: rtl/swmmf_in_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one unsigned sample per transfer.
// ----------------------------------------------------------------------------
interface swmmf_in_if;
  logic                            valid;
  logic                            ready;
  logic [swmmf_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/swmmf_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one filtered value and the full flag.
// ----------------------------------------------------------------------------
interface swmmf_out_if;
  logic                            valid;
  logic                            ready;
  logic [swmmf_pkg::SAMPLE_W-1:0]  filtered;
  logic                            window_full;

  modport source (output valid, output filtered, output window_full, input ready);
  modport sink   (input valid, input filtered, input window_full, output ready);
endinterface

// File: rtl/sliding_window_median_mean_filter.sv
// ----------------------------------------------------------------------------
// Sliding window median / mean filter
// Keeps the last window_len samples and returns either their lower median or
// their truncated mean for every sample taken in, or zero while not yet full.
// ----------------------------------------------------------------------------
// Path from an input transfer to result valid: a window not yet full goes
// straight to S_DONE. Median mode: one rank evaluation of a candidate per
// cycle over the n window entries in S_MED. Mean mode: serial accumulation
// in S_SUM, then one quotient bit per cycle in the divider (S_DIV).
// One sample is in flight at a time; the next input transfer is taken once
// the result register has been loaded. Synchronous active-low reset empties
// the window and restores window_len = 5 and median mode.
module sliding_window_median_mean_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  swmmf_in_if.sink                          in_ch,
  swmmf_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [swmmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swmmf_pkg::CFG_W-1:0]       cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MED,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

  localparam int SW = swmmf_pkg::SAMPLE_W;
  localparam int LW = swmmf_pkg::LEN_W;
  localparam int IW = swmmf_pkg::IDX_W;
  localparam int AW = swmmf_pkg::SUM_W;
  localparam int DW = swmmf_pkg::DCNT_W;
  localparam int WM = swmmf_pkg::WIN_MAX;

  state_t          state_r, state_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic            mode_r, mode_nxt;
  logic [LW-1:0]   fill_r, fill_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   acc_r, acc_nxt;
  logic [LW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   dcnt_r, dcnt_nxt;
  logic [SW-1:0]   res_r, res_nxt;
  logic            full_r, full_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [SW-1:0]   out_filtered_r, out_filtered_nxt;
  logic            out_full_r, out_full_nxt;

  logic [SW-1:0]   win_r [WM];

  logic            in_xfer;
  logic [SW-1:0]   cand;
  logic [WM-1:0]   lt_mask, le_mask;
  logic [LW-1:0]   lt_cnt, le_cnt;
  logic [LW-1:0]   med_k;
  logic            last_idx;
  logic [LW-1:0]   fill_inc;
  logic [LW:0]     trial;
  logic            qbit;
  logic [LW-1:0]   cfg_len;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_xfer         = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_filtered_r;
  assign out_ch.window_full = out_full_r;

  // Shared read port of the window: candidate for ranking, addend for the sum.
  assign cand     = win_r[idx_r];
  assign last_idx = (LW'(idx_r) == len_r - LW'(1));
  assign med_k    = (len_r - LW'(1)) >> 1;

  // Rank unit: how many window entries lie below and at or below the candidate.
  always_comb begin
    for (int j = 0; j < WM; j++) begin
      lt_mask[j] = (LW'(j) < len_r) && (win_r[j] <  cand);
      le_mask[j] = (LW'(j) < len_r) && (win_r[j] <= cand);
    end
    lt_cnt = LW'($countones(lt_mask));
    le_cnt = LW'($countones(le_mask));
  end

  // Divider step: one restoring quotient bit per cycle.
  assign trial = {rem_r, acc_r[AW-1]};
  assign qbit  = (trial >= {1'b0, len_r});

  // Fill level after pushing a sample.
  assign fill_inc = (fill_r < len_r) ? fill_r + LW'(1) : len_r;

  // Clamp a written window length to 1..WIN_MAX.
  always_comb begin
    if (int'(cfg_wdata) > WM) begin
      cfg_len = LW'(WM);
    end else if (cfg_wdata == '0) begin
      cfg_len = LW'(1);
    end else begin
      cfg_len = LW'(cfg_wdata);
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt        = state_r;
    len_nxt          = len_r;
    mode_nxt         = mode_r;
    fill_nxt         = fill_r;
    idx_nxt          = idx_r;
    acc_nxt          = acc_r;
    rem_nxt          = rem_r;
    dcnt_nxt         = dcnt_r;
    res_nxt          = res_r;
    full_nxt         = full_r;
    out_valid_nxt    = out_valid_r;
    out_filtered_nxt = out_filtered_r;
    out_full_nxt     = out_full_r;

    // The result register empties on an output transfer.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          fill_nxt = fill_inc;
          full_nxt = (fill_inc == len_r);
          idx_nxt  = '0;
          acc_nxt  = '0;
          res_nxt  = '0;
          if (fill_inc != len_r) begin
            state_nxt = S_DONE;
          end else if (mode_r == swmmf_pkg::MODE_MEDIAN) begin
            state_nxt = S_MED;
          end else begin
            state_nxt = S_SUM;
          end
        end
      end
      S_MED: begin
        // The candidate whose rank range covers k is the lower median.
        if ((lt_cnt <= med_k && med_k < le_cnt) || last_idx) begin
          res_nxt   = cand;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_SUM: begin
        acc_nxt = acc_r + AW'(cand);
        if (last_idx) begin
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_DIV: begin
        rem_nxt  = qbit ? LW'(trial - {1'b0, len_r}) : LW'(trial);
        acc_nxt  = {acc_r[AW-2:0], qbit};
        dcnt_nxt = dcnt_r + DW'(1);
        if (dcnt_r == DW'(AW - 1)) begin
          res_nxt   = {acc_r[SW-2:0], qbit};
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt    = 1'b1;
          out_filtered_nxt = res_r;
          out_full_nxt     = full_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration writes must arrive only while the filter is idle; the block itself does not enforce it.
    if (cfg_we) begin
      case (cfg_index)
        swmmf_pkg::REG_WINDOW_LEN: begin
          len_nxt  = cfg_len;
          fill_nxt = '0;
        end
        swmmf_pkg::REG_MODE: begin
          mode_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LW'(swmmf_pkg::LEN_RESET);
      mode_r      <= swmmf_pkg::MODE_MEDIAN;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      mode_r      <= mode_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r          <= idx_nxt;
    acc_r          <= acc_nxt;
    rem_r          <= rem_nxt;
    dcnt_r         <= dcnt_nxt;
    res_r          <= res_nxt;
    full_r         <= full_nxt;
    out_filtered_r <= out_filtered_nxt;
    out_full_r     <= out_full_nxt;
  end

  // Window shift line: the newest sample enters at entry 0, so entries
  // 0..n-1 always hold the last n samples.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      win_r[0] <= in_ch.sample;
      for (int i = 1; i < WM; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // The fill level never passes the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_r)
    else $error("fill level above window length");

  // The ranking and summing index stays inside the window.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MED || state_r == S_SUM) |-> (LW'(idx_r) < len_r))
    else $error("window index beyond window length");

  // Only one sample is in flight: a transfer closes the input at once.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input taken while a sample is in flight");

  // A result appears only out of the completion state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion");

  // A window that is not full reports zero.
  a_not_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_full_r) |-> (out_filtered_r == '0))
    else $error("nonzero result for a partial window");

endmodule

// File: tb/tb_sliding_window_median_mean_filter.sv
// ----------------------------------------------------------------------------
// Sliding window median / mean filter: self-checking testbench
// Drives samples and register writes into the filter, keeps its own copy of
// the window to work out each expected result, and compares every result
// transfer with the oldest outstanding expectation. Both channels idle at
// random, and the run walks through many window lengths and both modes.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_mean_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1380;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 50;
  localparam int STALL_LIMIT   = 2000;

  typedef logic [swmmf_pkg::SAMPLE_W-1:0]  sample_t;
  typedef logic [swmmf_pkg::CFG_W-1:0]     cfg_data_t;
  typedef logic [swmmf_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    sample_t filtered;
    logic    window_full;
  } filter_result_t;

  // Tracks the window and the registers, and holds the results still due.
  class filter_scoreboard;
    sample_t          window [swmmf_pkg::WIN_MAX];
    int unsigned      fill;
    cfg_data_t        len_reg;
    logic             mode_reg;
    filter_result_t   due [$];
    int unsigned      fails;

    function new();
      foreach (window[i]) window[i] = '0;
      fill     = 0;
      len_reg  = cfg_data_t'(swmmf_pkg::LEN_RESET);
      mode_reg = swmmf_pkg::MODE_MEDIAN;
      fails    = 0;
    endfunction

    // A length write always empties the window; a mode write keeps it.
    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      if (idx == swmmf_pkg::REG_WINDOW_LEN) begin
        len_reg = data;
        fill    = 0;
      end else if (idx == swmmf_pkg::REG_MODE) begin
        mode_reg = data[0];
      end
    endfunction

    // Window length in use: zero acts as one, oversize is clamped.
    function int unsigned span();
      if (len_reg == 0) return 1;
      if (len_reg > swmmf_pkg::WIN_MAX) return swmmf_pkg::WIN_MAX;
      return len_reg;
    endfunction

    function sample_t lower_median(int unsigned n);
      sample_t sorted [swmmf_pkg::WIN_MAX];
      sample_t v;
      int      j;
      sorted = window;
      for (int i = 1; i < n; i++) begin
        v = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[(n - 1) / 2];
    endfunction

    function sample_t trunc_mean(int unsigned n);
      logic [swmmf_pkg::SUM_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < n; i++) sum += window[i];
      return sample_t'(sum / n);
    endfunction

    // Pushes an accepted sample and queues the result it produces.
    function void note_sample(sample_t s);
      int unsigned    n;
      filter_result_t res;
      n = span();
      if (fill < n) begin
        window[fill] = s;
        fill++;
      end else begin
        for (int i = 0; i + 1 < n; i++) window[i] = window[i+1];
        window[n-1] = s;
      end
      res.window_full = (fill == n);
      res.filtered    = '0;
      if (res.window_full)
        res.filtered = (mode_reg == swmmf_pkg::MODE_MEDIAN) ?
                       lower_median(n) : trunc_mean(n);
      due.push_back(res);
    endfunction

    function void check_output(sample_t filtered, logic window_full);
      filter_result_t res;
      if (due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("result with none due: filtered %h window_full %b",
                   filtered, window_full);
        return;
      end
      res = due.pop_front();
      if (res.filtered !== filtered || res.window_full !== window_full) begin
        fails++;
        if (fails <= 10)
          $display("wrong result: filtered exp %h got %h, window_full exp %b got %b",
                   res.filtered, filtered, res.window_full, window_full);
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic      cfg_we    = 1'b0;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_wdata = '0;

  swmmf_in_if  in_ch ();
  swmmf_out_if out_ch ();

  filter_scoreboard sb;
  bit               steady = 1'b0;
  int               idle_cycles = 0;

  sliding_window_median_mean_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Ends the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("sliding_window_median_mean_filter: mismatch");
      $finish;
    end
  end

  // Register write; cfg_we drops again before the task returns so writes never abut.
  task automatic write_cfg(cfg_idx_t idx, cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one sample after a random gap and waits for its transfer.
  task automatic send_sample(sample_t s);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  // Holds the sender until every due result has come and the block is quiet.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mix of full-range values, extremes and near ties around a base value.
  function automatic sample_t pick_sample(sample_t base);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(swmmf_pkg::SAMPLE_W-1){1'b0}}};
      3:       return {1'b0, {(swmmf_pkg::SAMPLE_W-1){1'b1}}};
      4, 5:    return base + sample_t'($urandom_range(0, 7));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Result side: random stall before each transfer, then check it.
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
      sb.check_output(out_ch.filtered, out_ch.window_full);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned      sent;
    int unsigned      n;
    int unsigned      count;
    int unsigned      pause_at;
    cfg_data_t        len;
    sample_t          base;
    sb = new();
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: median of five, ordered as unsigned values.
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0001);

    // Mode change keeps the full window.
    wait_drained();
    write_cfg(swmmf_pkg::REG_MODE, cfg_data_t'(swmmf_pkg::MODE_MEAN));
    send_sample(16'hFFFF);

    // Zero length behaves as a single-sample window.
    wait_drained();
    write_cfg(swmmf_pkg::REG_WINDOW_LEN, '0);
    write_cfg(swmmf_pkg::REG_MODE, cfg_data_t'(swmmf_pkg::MODE_MEDIAN));
    send_sample(16'h1234);
    send_sample(16'hFFFF);

    // Largest window at full scale needs the wide sum.
    wait_drained();
    write_cfg(swmmf_pkg::REG_WINDOW_LEN, cfg_data_t'(swmmf_pkg::WIN_MAX));
    write_cfg(swmmf_pkg::REG_MODE, cfg_data_t'(swmmf_pkg::MODE_MEAN));
    repeat (swmmf_pkg::WIN_MAX) send_sample(16'hFFFF);

    // Random phases, each with its own mode and idling pattern, most with a new length.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       len = '0;
          1:       len = cfg_data_t'(1);
          2:       len = cfg_data_t'(swmmf_pkg::WIN_MAX);
          3:       len = '1;
          4:       len = cfg_data_t'(swmmf_pkg::WIN_MAX + 1);
          default: len = cfg_data_t'($urandom_range(1, swmmf_pkg::WIN_MAX));
        endcase
        write_cfg(swmmf_pkg::REG_WINDOW_LEN, len);
      end
      write_cfg(swmmf_pkg::REG_MODE,
                {(swmmf_pkg::CFG_W-1)'($urandom), 1'($urandom)});
      n        = sb.span();
      count    = $urandom_range(n, 4 * n + 8);
      pause_at = $urandom_range(0, count - 1);
      base     = sample_t'($urandom);
      for (int k = 0; k < count; k++) begin
        if (k == pause_at && $urandom_range(0, 2) == 0) wait_drained();
        send_sample(pick_sample(base));
      end
      sent += count;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.due.size() == 0)
      $display("sliding_window_median_mean_filter: match");
    else
      $display("sliding_window_median_mean_filter: mismatch");
    $finish;
  end

endmodule
